[hw/rtl/dfs_pkg.sv]
package dfs_pkg;

  localparam int NODES = 64;
  localparam int NW = 6;
  localparam int ECAP = 256;
  localparam int PW = 9;
  localparam logic [PW-1:0] NIL = 9'(ECAP);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] node_a;
    logic [5:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       related;
    logic [7:0] time_in_a;
    logic [7:0] time_out_a;
    logic [7:0] time_in_b;
    logic [7:0] time_out_b;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD1, ST_ADD2, ST_CLR, ST_VISIT, ST_TOP, ST_EDGE, ST_CHILD,
    ST_QA, ST_QB, ST_QR, ST_DONE
  } state_t;

endpackage

[hw/rtl/dfs_entry_exit_time_ancestor_check_unit.sv]
// channel | dir | payload             | handshake
// in      | in  | dfs_pkg::in_item_t  | in_valid / in_ready
// out     | out | dfs_pkg::out_item_t | out_valid / out_ready
// cfg     | in  | root_node @ 0       | apb, pready high
// add: ADD1 then ADD2 (ADD1 only when the store is full), query: QA, QB, QR, clear: sweep of the 64 node rows
// run: the clear sweep, then a depth-first walk through visit, top, edge and child steps
// the walk steps through its states under the sequencer
// reset is synchronous; node lists and times are cleared by valid bits at once
// a result holds in the output register until taken; ready stays low meanwhile
module dfs_entry_exit_time_ancestor_check_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dfs_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [5:0] root_node;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {26'd0, root_node} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= 6'd1;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      root_node <= pwdata[5:0];
    end
  end

  dfs_core u_core (
    .clk(clk), .rst(rst), .root_node(root_node),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

[hw/rtl/dfs_core.sv]
module dfs_core (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         root_node,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dfs_pkg::out_item_t out_data
);
  // node row: head, tail, enter, leave; valid bits give reset value
  logic [dfs_pkg::PW-1:0] head_m [dfs_pkg::NODES];
  logic [dfs_pkg::PW-1:0] tail_m [dfs_pkg::NODES];
  logic [7:0] ent_m [dfs_pkg::NODES];
  logic [7:0] lv_m  [dfs_pkg::NODES];
  logic [dfs_pkg::NODES-1:0] lvalid, seen;
  logic [dfs_pkg::PW-1:0] nxt_m [dfs_pkg::ECAP];
  logic [dfs_pkg::NW-1:0] nb_m [dfs_pkg::ECAP];
  logic [dfs_pkg::NW-1:0] sk_node [dfs_pkg::NODES];
  logic [dfs_pkg::PW-1:0] sk_cur [dfs_pkg::NODES];

  dfs_pkg::state_t state, state_next;
  dfs_pkg::in_item_t it;
  logic [8:0] used;
  logic [7:0] stamp;
  logic [6:0] depth;
  logic [6:0] sweep;
  logic [5:0] cur_n;
  logic [dfs_pkg::PW-1:0] cur_c;
  logic [5:0] child;
  logic [7:0] ia, oa;
  logic sa;
  logic run_after;
  logic [dfs_pkg::PW-1:0] tail_r, head_now;
  logic [5:0] from_n, to_n;
  logic full;

  assign from_n = (state == dfs_pkg::ST_ADD1) ? it.node_a : it.node_b;
  assign to_n = (state == dfs_pkg::ST_ADD1) ? it.node_b : it.node_a;
  assign head_now = lvalid[child] ? head_m[child] : dfs_pkg::NIL;
  assign full = (used > 9'(dfs_pkg::ECAP - 2));

  always_comb begin
    state_next = state;
    case (state)
      dfs_pkg::ST_IDLE: if (in_valid) begin
        case (in_data.cmd)
          dfs_pkg::CMD_ADD: state_next = dfs_pkg::ST_ADD1;
          dfs_pkg::CMD_QUERY: state_next = dfs_pkg::ST_QA;
          default: state_next = dfs_pkg::ST_CLR;
        endcase
      end
      dfs_pkg::ST_ADD1: state_next = full ? dfs_pkg::ST_DONE : dfs_pkg::ST_ADD2;
      dfs_pkg::ST_ADD2: state_next = dfs_pkg::ST_DONE;
      dfs_pkg::ST_CLR: if (sweep == 7'(dfs_pkg::NODES - 1)) begin
        state_next = run_after ? dfs_pkg::ST_VISIT : dfs_pkg::ST_DONE;
      end
      dfs_pkg::ST_VISIT: state_next = dfs_pkg::ST_TOP;
      dfs_pkg::ST_TOP: begin
        if (depth == 7'd0) state_next = dfs_pkg::ST_DONE;
        else state_next = dfs_pkg::ST_EDGE;
      end
      // an exhausted list pops straight back to the new top
      dfs_pkg::ST_EDGE: state_next = (cur_c == dfs_pkg::NIL) ? dfs_pkg::ST_TOP : dfs_pkg::ST_CHILD;
      dfs_pkg::ST_CHILD: state_next = seen[child] ? dfs_pkg::ST_TOP : dfs_pkg::ST_VISIT;
      dfs_pkg::ST_QA: state_next = dfs_pkg::ST_QB;
      dfs_pkg::ST_QB: state_next = dfs_pkg::ST_QR;
      dfs_pkg::ST_QR: state_next = dfs_pkg::ST_DONE;
      dfs_pkg::ST_DONE: if (out_ready) state_next = dfs_pkg::ST_IDLE;
      default: state_next = dfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == dfs_pkg::ST_IDLE);
    out_valid = (state == dfs_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfs_pkg::ST_IDLE;
      lvalid <= '0;
      seen <= '0;
      used <= '0;
      stamp <= 8'd1;
      depth <= '0;
      sweep <= '0;
      run_after <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        dfs_pkg::ST_IDLE: if (in_valid) begin
          it <= in_data;
          out_data <= '0;
          sweep <= '0;
          run_after <= (in_data.cmd == dfs_pkg::CMD_RUN);
          tail_r <= lvalid[in_data.node_a] ? tail_m[in_data.node_a] : dfs_pkg::NIL;
          if (in_data.cmd == dfs_pkg::CMD_CLEAR) begin
            lvalid <= '0;
            used <= '0;
          end
          if (in_data.cmd == dfs_pkg::CMD_RUN || in_data.cmd == dfs_pkg::CMD_CLEAR) begin
            seen <= '0;
            stamp <= 8'd1;
            depth <= '0;
          end
        end
        dfs_pkg::ST_ADD1, dfs_pkg::ST_ADD2: begin
          if (state == dfs_pkg::ST_ADD1 && full) begin
            out_data.status <= 1'b1;
          end else begin
            nb_m[used[7:0]] <= to_n;
            nxt_m[used[7:0]] <= dfs_pkg::NIL;
            if (tail_r != dfs_pkg::NIL) nxt_m[tail_r[7:0]] <= used;
            else head_m[from_n] <= used;
            tail_m[from_n] <= used;
            lvalid[from_n] <= 1'b1;
            used <= used + 9'd1;
            // tail of the second endpoint; a self loop sees the entry just added
            if (state == dfs_pkg::ST_ADD1) begin
              if (it.node_b == it.node_a) tail_r <= used;
              else tail_r <= lvalid[it.node_b] ? tail_m[it.node_b] : dfs_pkg::NIL;
            end
          end
        end
        dfs_pkg::ST_CLR: begin
          // zero stamps of every node row, one per cycle
          ent_m[sweep[5:0]] <= 8'd0;
          lv_m[sweep[5:0]] <= 8'd0;
          sweep <= sweep + 7'd1;
          child <= root_node;
        end
        dfs_pkg::ST_VISIT: begin
          seen[child] <= 1'b1;
          ent_m[child] <= stamp;
          stamp <= stamp + 8'd1;
          sk_node[depth[5:0]] <= child;
          sk_cur[depth[5:0]] <= head_now;
          depth <= depth + 7'd1;
        end
        dfs_pkg::ST_TOP: if (depth != 7'd0) begin
          cur_n <= sk_node[depth[5:0] - 6'd1];
          cur_c <= sk_cur[depth[5:0] - 6'd1];
        end
        dfs_pkg::ST_EDGE: begin
          if (cur_c == dfs_pkg::NIL) begin
            lv_m[cur_n] <= stamp;
            stamp <= stamp + 8'd1;
            depth <= depth - 7'd1;
          end else begin
            child <= nb_m[cur_c[7:0]];
            sk_cur[depth[5:0] - 6'd1] <= nxt_m[cur_c[7:0]];
          end
        end
        // an unvisited node reads stamps of zero
        dfs_pkg::ST_QA: begin
          ia <= seen[it.node_a] ? ent_m[it.node_a] : 8'd0;
          oa <= seen[it.node_a] ? lv_m[it.node_a] : 8'd0;
          sa <= seen[it.node_a];
        end
        dfs_pkg::ST_QB: begin
          out_data.time_in_a <= ia;
          out_data.time_out_a <= oa;
          out_data.time_in_b <= seen[it.node_b] ? ent_m[it.node_b] : 8'd0;
          out_data.time_out_b <= seen[it.node_b] ? lv_m[it.node_b] : 8'd0;
          sa <= sa && seen[it.node_b];
        end
        dfs_pkg::ST_QR: begin
          out_data.related <= sa &&
            ((out_data.time_in_a > out_data.time_in_b &&
              out_data.time_out_a < out_data.time_out_b) ||
             (out_data.time_in_a < out_data.time_in_b &&
              out_data.time_out_a > out_data.time_out_b));
        end
        default: ;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) in_ready |-> !out_valid;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");

  property p_used_even;
    @(posedge clk) disable iff (rst) (state == dfs_pkg::ST_IDLE) |-> !used[0];
  endproperty
  a_used_even: assert property (p_used_even) else $error("odd entry count at rest");

  property p_depth_bound;
    @(posedge clk) disable iff (rst) depth <= 7'(dfs_pkg::NODES);
  endproperty
  a_depth_bound: assert property (p_depth_bound) else $error("stack overflow");
endmodule
